// ===== rtl/sntpco_pkg.sv =====
// Package for the SNTP response checker and clock offset core.
// Holds status codes, register indexes and the fixed conversion constants.
// No dependencies.
package sntpco_pkg;

    typedef enum logic [3:0] {
        ST_OK_SERVER = 4'd0,
        ST_OK_BCAST  = 4'd1,
        ST_BAD_SRC   = 4'd2,
        ST_SHORT     = 4'd3,
        ST_BAD_MODE  = 4'd4,
        ST_KOD       = 4'd5,
        ST_ALARM     = 4'd6,
        ST_BAD_ORIG  = 4'd7,
        ST_REQ       = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        REG_UPDATE_DELAY = 3'd0,
        REG_RETRY_BASE   = 3'd1,
        REG_RETRY_MAX    = 3'd2,
        REG_SERVER_PORT  = 3'd3,
        REG_CHECK_LEVEL  = 3'd4
    } reg_index_t;

    localparam logic       CMD_REQUEST    = 1'b0;
    localparam logic [2:0] MODE_SERVER    = 3'd4;
    localparam logic [2:0] MODE_BCAST     = 3'd5;
    localparam logic [1:0] LEAP_ALARM     = 2'd3;
    localparam logic [15:0] MIN_LEN       = 16'd48;

    localparam logic [31:0] MIN_UPDATE    = 32'd15000;
    localparam logic [31:0] RST_UPDATE    = 32'd3600000;
    localparam logic [31:0] RST_RETRY     = 32'd3000;
    localparam logic [31:0] RST_RETRY_MAX = 32'd30000;
    localparam logic [15:0] RST_PORT      = 16'd123;
    localparam logic [1:0]  RST_LEVEL     = 2'd2;

    localparam logic [31:0] SEC_1900_1970 = 32'd2208988800;
    localparam logic [31:0] SEC_1970_2036 = 32'd2085978496;

    // ceil(2^44 / 4295): exact fraction-to-microsecond quotient for 32-bit input
    localparam logic [31:0] FRAC_MAGIC    = 32'd4095968812;
    // ceil(2^50 / 10^6): exact quotient by 10^6 for 32-bit input
    localparam logic [31:0] MEG_MAGIC     = 32'd1125899907;
    localparam logic [19:0] US_PER_SEC    = 20'd1000000;
    localparam logic [19:0] HALF_SEC_US   = 20'd500000;
    // bias of whole seconds that keeps the microsecond sum nonnegative
    localparam logic [12:0] SEC_BIAS      = 13'd2200;
    localparam logic [31:0] US_BIAS       = 32'd2200000000;

    function automatic logic [31:0] ntp_to_unix(input logic [31:0] s);
        logic [31:0] r;
        r = s[31] ? (s - SEC_1900_1970) : (s + SEC_1970_2036);
        return r;
    endfunction

endpackage

// ===== rtl/sntp_response_check_and_offset_core.sv =====
// Top level of the SNTP response checker and clock offset core.
// Checks client events, tracks retry delay and computes the corrected clock.
// Depends on sntpco_pkg.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  s_       | in        | s_tvalid / s_tready  | s_tdata (event), s_tuser (cmd)
//  m_       | out       | m_tvalid / m_tready  | m_tdata (result), m_tuser (status)
//  cfg_     | in        | cfg_wr_en            | cfg_index, cfg_data
//
// One word in, one word out. A word passes the input register, check stage,
// offset sum stage, divide-by-10^6 multiply stage and output register;
// one word is accepted per cycle while the output is taken. Checks and the
// retry/send state update in the check stage, so back-to-back events see the
// state left by the previous one. Reset is synchronous on aresetn low and
// empties the pipeline. A stalled output holds; earlier stages keep filling
// bubbles, and s_tready drops only when every stage holds a word.
module sntp_response_check_and_offset_core
    import sntpco_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // srv_ip[31:0] src_port[47:32] pkt_len[63:48] header_byte[71:64]
    // stratum[79:72] orig_s[111:80] orig_us[143:112] rx_stamp[207:144]
    // tx_stamp[271:208] now_sec[303:272] now_us[323:304] zero[327:324]
    input  logic [327:0] s_tdata,
    // command[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // leap[1:0] time_valid[2] time_sec[34:3] time_us[54:35]
    // next_delay_ms[86:55] next_srv[87]
    output logic [87:0]  m_tdata,
    // status[3:0]
    output logic [3:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    // configuration
    logic [31:0] update_delay_reg, retry_base_reg, retry_max_reg;
    logic [15:0] server_port_reg;
    logic [1:0]  check_level_reg;

    // event state
    logic [31:0] last_server_reg, sent_sec_reg, retry_delay_reg;
    logic [19:0] sent_us_reg;
    logic [31:0] retry_delay_next;

    // stage A: input register
    logic         a_valid_reg;
    logic         a_cmd_reg;
    logic [323:0] a_data_reg;

    // stage B: checked
    logic        b_valid_reg;
    status_t     b_status_reg;
    logic [1:0]  b_leap_reg;
    logic [31:0] b_delay_reg;
    logic        b_nxt_reg;
    logic [31:0] b_srx_reg, b_stx_reg, b_osec_reg, b_ous_reg, b_nsec_reg;
    logic [19:0] b_urx_reg, b_utx_reg, b_nus_reg;

    // stage C: offset sum
    logic        c_valid_reg;
    status_t     c_status_reg;
    logic [1:0]  c_leap_reg;
    logic [31:0] c_delay_reg;
    logic        c_nxt_reg;
    logic [31:0] c_stx_reg;
    logic [19:0] c_utx_reg;
    logic [31:0] c_vp_reg, c_hsec_reg;

    // stage D: quotient by 10^6
    logic        d_valid_reg;
    status_t     d_status_reg;
    logic [1:0]  d_leap_reg;
    logic [31:0] d_delay_reg;
    logic        d_nxt_reg;
    logic [31:0] d_stx_reg;
    logic [19:0] d_utx_reg;
    logic [31:0] d_vp_reg, d_hsec_reg;
    logic [12:0] d_q_reg;

    // stage E: output register
    logic        e_valid_reg;
    status_t     e_status_reg;
    logic [1:0]  e_leap_reg;
    logic        e_tvalid_reg;
    logic [31:0] e_tsec_reg;
    logic [19:0] e_tus_reg;
    logic [31:0] e_delay_reg;
    logic        e_nxt_reg;

    logic e_ready, d_ready, c_ready, b_ready, a_ready;

    assign e_ready  = !e_valid_reg || m_tready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            update_delay_reg <= RST_UPDATE;
            retry_base_reg   <= RST_RETRY;
            retry_max_reg    <= RST_RETRY_MAX;
            server_port_reg  <= RST_PORT;
            check_level_reg  <= RST_LEVEL;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_UPDATE_DELAY: update_delay_reg <=
                    (cfg_data < MIN_UPDATE) ? MIN_UPDATE : cfg_data;
                REG_RETRY_BASE:   retry_base_reg   <= cfg_data;
                REG_RETRY_MAX:    retry_max_reg    <= cfg_data;
                REG_SERVER_PORT:  server_port_reg  <= cfg_data[15:0];
                REG_CHECK_LEVEL:  check_level_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage A ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && s_tvalid) begin
            a_cmd_reg  <= s_tuser[0];
            a_data_reg <= s_tdata[323:0];
        end
    end

    // field view of stage A
    logic [31:0] a_addr, a_osec, a_ous, a_nsec;
    logic [15:0] a_port, a_len;
    logic [7:0]  a_hdr, a_strat;
    logic [63:0] a_rx, a_tx;
    logic [19:0] a_nus;
    logic [1:0]  a_leap;
    logic [2:0]  a_mode;

    assign a_addr  = a_data_reg[31:0];
    assign a_port  = a_data_reg[47:32];
    assign a_len   = a_data_reg[63:48];
    assign a_hdr   = a_data_reg[71:64];
    assign a_strat = a_data_reg[79:72];
    assign a_osec  = a_data_reg[111:80];
    assign a_ous   = a_data_reg[143:112];
    assign a_rx    = a_data_reg[207:144];
    assign a_tx    = a_data_reg[271:208];
    assign a_nsec  = a_data_reg[303:272];
    assign a_nus   = a_data_reg[323:304];
    assign a_leap  = a_hdr[7:6];
    assign a_mode  = a_hdr[2:0];

    status_t     a_status_next;
    logic [31:0] a_delay_next;
    logic        a_nxt_next;
    logic [31:0] retry_dbl;
    logic [63:0] rx_frac_prod, tx_frac_prod;

    assign retry_dbl    = {retry_delay_reg[30:0], 1'b0};
    assign rx_frac_prod = 64'(a_rx[31:0]) * 64'(FRAC_MAGIC);
    assign tx_frac_prod = 64'(a_tx[31:0]) * 64'(FRAC_MAGIC);

    always_comb begin
        a_status_next    = ST_REQ;
        a_delay_next     = '0;
        a_nxt_next       = 1'b0;
        retry_delay_next = retry_delay_reg;
        if (a_cmd_reg != CMD_REQUEST) begin
            if ((check_level_reg != 2'd0)
                && (a_addr != last_server_reg || a_port != server_port_reg)) begin
                a_status_next = ST_BAD_SRC;
            end else if (a_len < MIN_LEN) begin
                a_status_next = ST_SHORT;
            end else if (a_mode != MODE_SERVER && a_mode != MODE_BCAST) begin
                a_status_next = ST_BAD_MODE;
            end else if (a_strat == 8'd0) begin
                a_status_next = ST_KOD;
            end else if (a_leap == LEAP_ALARM) begin
                a_status_next = ST_ALARM;
            end else if (a_mode == MODE_SERVER && check_level_reg[1]
                && (a_osec != sent_sec_reg || a_ous != 32'(sent_us_reg))) begin
                a_status_next = ST_BAD_ORIG;
            end else if (a_mode == MODE_SERVER) begin
                a_status_next = ST_OK_SERVER;
            end else begin
                a_status_next = ST_OK_BCAST;
            end

            if (a_status_next == ST_OK_SERVER || a_status_next == ST_OK_BCAST) begin
                a_delay_next     = update_delay_reg;
                retry_delay_next = retry_base_reg;
            end else begin
                a_delay_next = retry_delay_reg;
                a_nxt_next   = (a_status_next == ST_KOD) || (a_status_next == ST_ALARM);
                if (retry_dbl <= retry_max_reg && retry_dbl > retry_delay_reg) begin
                    retry_delay_next = retry_dbl;
                end
            end
        end
    end

    logic a_fire;
    assign a_fire = a_valid_reg && b_ready;

    // event state advances with the word leaving stage A
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_server_reg <= '0;
            sent_sec_reg    <= '0;
            sent_us_reg     <= '0;
            retry_delay_reg <= RST_RETRY;
        end else if (a_fire) begin
            retry_delay_reg <= retry_delay_next;
            if (a_cmd_reg == CMD_REQUEST) begin
                last_server_reg <= a_addr;
                sent_sec_reg    <= a_nsec;
                sent_us_reg     <= a_nus;
            end
        end
    end

    // ---------------- stage B ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_fire) begin
            b_status_reg <= a_status_next;
            b_leap_reg   <= (a_cmd_reg == CMD_REQUEST) ? 2'd0 : a_leap;
            b_delay_reg  <= a_delay_next;
            b_nxt_reg    <= a_nxt_next;
            b_srx_reg    <= ntp_to_unix(a_rx[63:32]);
            b_stx_reg    <= ntp_to_unix(a_tx[63:32]);
            b_urx_reg    <= rx_frac_prod[63:44];
            b_utx_reg    <= tx_frac_prod[63:44];
            b_osec_reg   <= a_osec;
            b_ous_reg    <= a_ous;
            b_nsec_reg   <= a_nsec;
            b_nus_reg    <= a_nus;
        end
    end

    // seconds and microseconds of the four-stamp difference, kept apart
    logic signed [34:0] b_sdiff;
    logic signed [34:0] b_udiff;
    logic signed [34:0] b_vp;
    logic [31:0]        b_hsec;

    assign b_sdiff = 35'(b_srx_reg) + 35'(b_stx_reg) - 35'(b_osec_reg) - 35'(b_nsec_reg);
    assign b_udiff = 35'(b_urx_reg) + 35'(b_utx_reg) - 35'(b_ous_reg) - 35'(b_nus_reg);
    assign b_vp    = 35'(b_nus_reg) + (b_udiff >>> 1)
                   + (b_sdiff[0] ? 35'(HALF_SEC_US) : 35'd0) + 35'(US_BIAS);
    assign b_hsec  = b_nsec_reg + b_sdiff[32:1];

    logic b_fire;
    assign b_fire = b_valid_reg && c_ready;

    // ---------------- stage C ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire) begin
            c_status_reg <= b_status_reg;
            c_leap_reg   <= b_leap_reg;
            c_delay_reg  <= b_delay_reg;
            c_nxt_reg    <= b_nxt_reg;
            c_stx_reg    <= b_stx_reg;
            c_utx_reg    <= b_utx_reg;
            c_vp_reg     <= b_vp[31:0];
            c_hsec_reg   <= b_hsec;
        end
    end

    logic [63:0] c_qprod;
    assign c_qprod = 64'(c_vp_reg) * 64'(MEG_MAGIC);

    logic c_fire;
    assign c_fire = c_valid_reg && d_ready;

    // ---------------- stage D ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (d_ready) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_fire) begin
            d_status_reg <= c_status_reg;
            d_leap_reg   <= c_leap_reg;
            d_delay_reg  <= c_delay_reg;
            d_nxt_reg    <= c_nxt_reg;
            d_stx_reg    <= c_stx_reg;
            d_utx_reg    <= c_utx_reg;
            d_vp_reg     <= c_vp_reg;
            d_hsec_reg   <= c_hsec_reg;
            d_q_reg      <= c_qprod[62:50];
        end
    end

    logic [31:0] d_rem;
    logic        d_tvalid_next;
    logic [31:0] d_tsec_next;
    logic [19:0] d_tus_next;

    assign d_rem = d_vp_reg - 32'(d_q_reg) * 32'(US_PER_SEC);

    always_comb begin
        d_tvalid_next = 1'b0;
        d_tsec_next   = '0;
        d_tus_next    = '0;
        case (d_status_reg)
            ST_OK_SERVER: begin
                d_tvalid_next = 1'b1;
                d_tsec_next   = d_hsec_reg + 32'(d_q_reg) - 32'(SEC_BIAS);
                d_tus_next    = d_rem[19:0];
            end
            ST_OK_BCAST: begin
                d_tvalid_next = 1'b1;
                d_tsec_next   = d_stx_reg;
                d_tus_next    = d_utx_reg;
            end
            default: ;
        endcase
    end

    logic d_fire;
    assign d_fire = d_valid_reg && e_ready;

    // ---------------- stage E ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (e_ready) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_fire) begin
            e_status_reg <= d_status_reg;
            e_leap_reg   <= d_leap_reg;
            e_tvalid_reg <= d_tvalid_next;
            e_tsec_reg   <= d_tsec_next;
            e_tus_reg    <= d_tus_next;
            e_delay_reg  <= d_delay_reg;
            e_nxt_reg    <= d_nxt_reg;
        end
    end

    assign m_tvalid = e_valid_reg;
    assign m_tuser  = e_status_reg;
    assign m_tdata  = {e_nxt_reg, e_delay_reg, e_tus_reg, e_tsec_reg,
                       e_tvalid_reg, e_leap_reg};

    // ---------------- assertions ----------------
    a_time_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |->
            (m_tuser == ST_OK_SERVER || m_tuser == ST_OK_BCAST))
        else $error("time marked valid on a failed or request word");

    a_next_server_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[87]) |-> (m_tuser == ST_KOD || m_tuser == ST_ALARM))
        else $error("next server flagged without kiss of death or alarm");

    a_request_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_REQ) |-> (m_tdata == 88'd0))
        else $error("request word carries nonzero result fields");

    a_retry_restore: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_fire && a_cmd_reg != CMD_REQUEST
            && (a_status_next == ST_OK_SERVER || a_status_next == ST_OK_BCAST)
            && !cfg_wr_en)
            |=> (retry_delay_reg == retry_base_reg))
        else $error("retry delay not restored after a good response");

endmodule

// ===== tb/sntp_offset_checker.sv =====
// Checker for the SNTP response checker and clock offset core.
// Watches the event, result and register ports, predicts every result word and compares it.
// Depends on sntpco_pkg.
module sntp_offset_checker
    import sntpco_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [327:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [87:0]  m_tdata,
    input  logic [3:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           outstanding,
    output int           checked
);

    typedef struct {
        status_t     status;
        logic [1:0]  leap;
        logic        valid;
        logic [31:0] sec;
        logic [19:0] usec;
        logic [31:0] delay;
        logic        next_srv;
    } clock_result_t;

    clock_result_t clock_q[$];

    logic [31:0] update_ms;
    logic [31:0] base_ms;
    logic [31:0] cap_ms;
    logic [15:0] port_req;
    logic [1:0]  level;
    logic [31:0] srv_addr;
    logic [31:0] sent_s;
    logic [31:0] sent_u;
    logic [31:0] retry_ms;

    function automatic logic [31:0] unix_seconds(input logic [31:0] ntp_s);
        if (ntp_s[31])
            return ntp_s - SEC_1900_1970;
        return ntp_s + SEC_1970_2036;
    endfunction

    function automatic longint stamp_to_us(input logic [63:0] st);
        logic [31:0] frac_us;
        frac_us = st[31:0] / 32'd4295;
        return longint'({32'd0, unix_seconds(st[63:32])}) * 1000000
            + longint'({32'd0, frac_us});
    endfunction

    function automatic clock_result_t predict_event(input logic cmd, input logic [327:0] w);
        clock_result_t res;
        logic [31:0] addr;
        logic [15:0] port;
        logic [15:0] len;
        logic [7:0]  hdr;
        logic [7:0]  strat;
        logic [31:0] osec;
        logic [31:0] ous;
        logic [63:0] rx;
        logic [63:0] tx;
        logic [31:0] nsec;
        logic [19:0] nus;
        logic [2:0]  mode;
        logic [31:0] doubled;
        longint      o;
        longint      n;
        longint      d;
        longint      t;
        longint      q;
        longint      r;
        addr  = w[31:0];
        port  = w[47:32];
        len   = w[63:48];
        hdr   = w[71:64];
        strat = w[79:72];
        osec  = w[111:80];
        ous   = w[143:112];
        rx    = w[207:144];
        tx    = w[271:208];
        nsec  = w[303:272];
        nus   = w[323:304];
        res.leap     = '0;
        res.valid    = 1'b0;
        res.sec      = '0;
        res.usec     = '0;
        res.delay    = '0;
        res.next_srv = 1'b0;
        if (cmd == CMD_REQUEST) begin
            srv_addr   = addr;
            sent_s     = nsec;
            sent_u     = {12'd0, nus};
            res.status = ST_REQ;
            return res;
        end
        res.leap = hdr[7:6];
        mode     = hdr[2:0];
        if (level >= 2'd1 && (addr != srv_addr || port != port_req))
            res.status = ST_BAD_SRC;
        else if (len < MIN_LEN)
            res.status = ST_SHORT;
        else if (mode != MODE_SERVER && mode != MODE_BCAST)
            res.status = ST_BAD_MODE;
        else if (strat == 8'd0)
            res.status = ST_KOD;
        else if (res.leap == LEAP_ALARM)
            res.status = ST_ALARM;
        else if (mode == MODE_SERVER && level >= 2'd2 && (osec != sent_s || ous != sent_u))
            res.status = ST_BAD_ORIG;
        else if (mode == MODE_SERVER)
            res.status = ST_OK_SERVER;
        else
            res.status = ST_OK_BCAST;

        if (res.status == ST_OK_BCAST) begin
            res.sec   = unix_seconds(tx[63:32]);
            res.usec  = 20'(tx[31:0] / 32'd4295);
            res.valid = 1'b1;
        end else if (res.status == ST_OK_SERVER) begin
            o = longint'({32'd0, osec}) * 1000000 + longint'({32'd0, ous});
            n = longint'({32'd0, nsec}) * 1000000 + longint'({44'd0, nus});
            d = (stamp_to_us(rx) + stamp_to_us(tx)) - (o + n);
            t = n + (d >>> 1);
            q = t / 1000000;
            r = t % 1000000;
            if (r < 0) begin
                r = r + 1000000;
                q = q - 1;
            end
            res.sec   = q[31:0];
            res.usec  = r[19:0];
            res.valid = 1'b1;
        end

        if (res.valid) begin
            retry_ms  = base_ms;
            res.delay = update_ms;
        end else begin
            res.next_srv = (res.status == ST_KOD || res.status == ST_ALARM);
            res.delay    = retry_ms;
            doubled      = retry_ms << 1;
            if (doubled <= cap_ms && doubled > retry_ms)
                retry_ms = doubled;
        end
        return res;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        clock_result_t want;
        if (!aresetn) begin
            update_ms = RST_UPDATE;
            base_ms   = RST_RETRY;
            cap_ms    = RST_RETRY_MAX;
            port_req  = RST_PORT;
            level     = RST_LEVEL;
            srv_addr  = '0;
            sent_s    = '0;
            sent_u    = '0;
            retry_ms  = RST_RETRY;
            clock_q.delete();
            outstanding <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_UPDATE_DELAY: update_ms = (cfg_data < MIN_UPDATE) ? MIN_UPDATE : cfg_data;
                    REG_RETRY_BASE:   base_ms   = cfg_data;
                    REG_RETRY_MAX:    cap_ms    = cfg_data;
                    REG_SERVER_PORT:  port_req  = cfg_data[15:0];
                    REG_CHECK_LEVEL:  level     = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                clock_q.push_back(predict_event(s_tuser[0], s_tdata));
            if (m_tvalid && m_tready) begin
                if (clock_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got status %0d",
                             $time, m_tuser);
                    fail_count++;
                end else begin
                    want = clock_q.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tuser));
                    check_field("leap", 32'(want.leap), 32'(m_tdata[1:0]));
                    check_field("time_valid", 32'(want.valid), 32'(m_tdata[2]));
                    check_field("time_sec", want.sec, m_tdata[34:3]);
                    check_field("time_us", 32'(want.usec), 32'(m_tdata[54:35]));
                    check_field("next_delay_ms", want.delay, m_tdata[86:55]);
                    check_field("next_srv", 32'(want.next_srv), 32'(m_tdata[87]));
                    checked++;
                end
            end
            outstanding <= clock_q.size();
        end
    end

endmodule

// ===== tb/sntp_response_check_and_offset_core_tb.sv =====
// Testbench top for the SNTP response checker and clock offset core.
// Drives request and response events, register settings and output stalls; sntp_offset_checker
// predicts and compares. Depends on sntpco_pkg, the core and sntp_offset_checker.
module sntp_response_check_and_offset_core_tb;
    import sntpco_pkg::*;

    localparam logic CMD_RESPONSE = 1'b1;
    localparam int   HOLD_CYCLES  = 300;
    localparam int   PHASE_ITEMS  = 238;

    typedef enum int {
        RK_SERVER, RK_BCAST, RK_BAD_ADDR, RK_BAD_PORT, RK_SHORT,
        RK_BAD_MODE, RK_KOD, RK_ALARM, RK_BAD_ORIG, RK_NOISE
    } resp_kind_t;

    typedef struct packed {
        logic [3:0]  pad;
        logic [19:0] now_us;
        logic [31:0] now_sec;
        logic [63:0] tx_stamp;
        logic [63:0] rx_stamp;
        logic [31:0] orig_us;
        logic [31:0] orig_s;
        logic [7:0]  stratum;
        logic [7:0]  header_byte;
        logic [15:0] pkt_len;
        logic [15:0] src_port;
        logic [31:0] srv_ip;
    } sntp_event_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [327:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [87:0]  m_tdata;
    logic [3:0]   m_tuser;
    logic         cfg_wr_en;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    int fail_count;
    int outstanding;
    int checked;

    int          max_gap;
    int          max_stall;
    bit          hold_output;
    int          sent;
    int          settings;
    logic [31:0] req_addr;
    logic [31:0] req_sec;
    logic [19:0] req_us;
    logic [15:0] port_cfg;

    sntp_response_check_and_offset_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sntp_offset_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    initial begin
        #4000000;
        $display("** sntp_response_check_and_offset_core: FAILED **");
        $finish;
    end

    function automatic sntp_event_t noise_event();
        sntp_event_t ev;
        ev.pad         = '0;
        ev.now_us      = 20'($urandom_range(0, 999999));
        ev.now_sec     = $urandom;
        ev.tx_stamp    = {$urandom, $urandom};
        ev.rx_stamp    = {$urandom, $urandom};
        ev.orig_us     = $urandom;
        ev.orig_s      = $urandom;
        ev.stratum     = 8'($urandom);
        ev.header_byte = 8'($urandom);
        ev.pkt_len     = 16'($urandom);
        ev.src_port    = 16'($urandom);
        ev.srv_ip      = $urandom;
        return ev;
    endfunction

    function automatic sntp_event_t request_event(input logic [31:0] addr,
                                                  input logic [31:0] sec,
                                                  input logic [19:0] usec);
        sntp_event_t ev;
        ev = noise_event();
        ev.srv_ip      = addr;
        ev.now_sec     = sec;
        ev.now_us      = usec;
        req_addr = addr;
        req_sec  = sec;
        req_us   = usec;
        return ev;
    endfunction

    function automatic sntp_event_t response_event(input resp_kind_t kind);
        sntp_event_t ev;
        logic [31:0] ntp_sec;
        int          pick;
        ev = noise_event();
        if (kind == RK_NOISE)
            return ev;
        ntp_sec = req_sec + SEC_1900_1970 + 32'($urandom_range(0, 4));
        ev.srv_ip      = req_addr;
        ev.src_port    = port_cfg;
        ev.pkt_len     = 16'($urandom_range(48, 1500));
        ev.header_byte = {2'($urandom_range(0, 2)), 3'($urandom), MODE_SERVER};
        ev.stratum     = 8'($urandom_range(1, 255));
        ev.orig_s      = req_sec;
        ev.orig_us     = {12'd0, req_us};
        ev.rx_stamp    = {ntp_sec, $urandom};
        ev.tx_stamp    = {ntp_sec + 32'($urandom_range(0, 1)), $urandom};
        ev.now_sec     = req_sec + 32'($urandom_range(0, 8));
        if ($urandom_range(0, 7) == 0) begin
            ev.rx_stamp = {$urandom, $urandom};
            ev.tx_stamp = {$urandom, $urandom};
        end
        case (kind)
            RK_BCAST: begin
                ev.header_byte[2:0] = MODE_BCAST;
                ev.orig_s   = $urandom;
                ev.orig_us  = $urandom;
            end
            RK_BAD_ADDR: ev.srv_ip ^= 32'd1 << $urandom_range(0, 31);
            RK_BAD_PORT: ev.src_port ^= 16'($urandom_range(1, 65535));
            RK_SHORT:    ev.pkt_len = 16'($urandom_range(0, 47));
            RK_BAD_MODE: begin
                pick = $urandom_range(0, 5);
                ev.header_byte[2:0] = (pick < 4) ? 3'(pick) : 3'(pick + 2);
            end
            RK_KOD:      ev.stratum = 8'd0;
            RK_ALARM:    ev.header_byte[7:6] = LEAP_ALARM;
            RK_BAD_ORIG: begin
                if ($urandom_range(0, 1) == 0)
                    ev.orig_s ^= 32'd1 << $urandom_range(0, 31);
                else
                    ev.orig_us ^= 32'd1 << $urandom_range(0, 31);
            end
            default: ;
        endcase
        return ev;
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 4;
            default: return 16;
        endcase
    endfunction

    task automatic send_word(input logic cmd, input sntp_event_t ev);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ev;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic send_random_item();
        int          r;
        int          k;
        logic [31:0] addr;
        logic [31:0] sec;
        resp_kind_t  kind;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            addr = $urandom;
            sec  = $urandom;
            case ($urandom_range(0, 15))
                0: addr = '0;
                1: addr = '1;
                2: sec  = '0;
                3: sec  = '1;
                default: ;
            endcase
            send_word(CMD_REQUEST, request_event(addr, sec, 20'($urandom_range(0, 999999))));
        end else begin
            k = $urandom_range(0, 99);
            if (k < 45)      kind = RK_SERVER;
            else if (k < 55) kind = RK_BCAST;
            else if (k < 60) kind = RK_BAD_ADDR;
            else if (k < 64) kind = RK_BAD_PORT;
            else if (k < 68) kind = RK_SHORT;
            else if (k < 73) kind = RK_BAD_MODE;
            else if (k < 78) kind = RK_KOD;
            else if (k < 83) kind = RK_ALARM;
            else if (k < 90) kind = RK_BAD_ORIG;
            else             kind = RK_NOISE;
            send_word(CMD_RESPONSE, response_event(kind));
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic apply_config(input logic [31:0] upd, input logic [31:0] base,
                                input logic [31:0] cap, input logic [31:0] port_word,
                                input logic [31:0] level_word);
        write_reg(REG_UPDATE_DELAY, upd);
        write_reg(REG_RETRY_BASE, base);
        write_reg(REG_RETRY_MAX, cap);
        write_reg(REG_SERVER_PORT, port_word);
        write_reg(REG_CHECK_LEVEL, level_word);
        for (int k = int'(REG_CHECK_LEVEL) + 1; k < 8; k++)
            write_reg(3'(k), $urandom);
        cfg_wr_en <= 1'b0;
        port_cfg = port_word[15:0];
        settings++;
    endtask

    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_output = 1'b0;
            end else begin
                stall = $urandom_range(0, max_stall);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : event_source
        sntp_event_t ev;
        max_gap     = 16;
        max_stall   = 16;
        hold_output = 1'b0;
        sent        = 0;
        settings    = 1;
        port_cfg    = RST_PORT;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed events at reset register values
        send_word(CMD_REQUEST, request_event(32'h0, 32'h0, 20'd0));
        ev = response_event(RK_SERVER);
        ev.rx_stamp = {32'h7FFF_FFFF, 32'hFFFF_FFFF};
        ev.tx_stamp = {32'h7FFF_FFFF, 32'hFFFF_FFFF};
        ev.now_sec  = '1;
        ev.now_us   = 20'd999999;
        send_word(CMD_RESPONSE, ev);
        ev = response_event(RK_BCAST);
        ev.tx_stamp = {32'h0, 32'hFFFF_FFFF};
        send_word(CMD_RESPONSE, ev);
        ev = response_event(RK_BCAST);
        ev.tx_stamp = {32'hFFFF_FFFF, 32'h0};
        send_word(CMD_RESPONSE, ev);
        send_word(CMD_REQUEST, request_event('1, '1, 20'd999999));
        ev = response_event(RK_SERVER);
        ev.rx_stamp = {SEC_1900_1970, 32'h0};
        ev.tx_stamp = {SEC_1900_1970, 32'h0};
        ev.now_sec  = '0;
        ev.now_us   = '0;
        send_word(CMD_RESPONSE, ev);
        send_word(CMD_RESPONSE, response_event(RK_BAD_ADDR));
        send_word(CMD_RESPONSE, response_event(RK_BAD_PORT));
        ev = response_event(RK_SERVER);
        ev.pkt_len = MIN_LEN - 16'd1;
        send_word(CMD_RESPONSE, ev);
        ev = response_event(RK_SERVER);
        ev.pkt_len = MIN_LEN;
        send_word(CMD_RESPONSE, ev);
        ev = response_event(RK_SERVER);
        ev.header_byte[2:0] = 3'd0;
        send_word(CMD_RESPONSE, ev);
        ev = response_event(RK_SERVER);
        ev.header_byte[2:0] = 3'd3;
        send_word(CMD_RESPONSE, ev);
        ev = response_event(RK_SERVER);
        ev.header_byte[2:0] = 3'd6;
        send_word(CMD_RESPONSE, ev);
        ev = response_event(RK_SERVER);
        ev.header_byte = 8'hFF;
        ev.pkt_len     = 16'hFFFF;
        send_word(CMD_RESPONSE, ev);
        send_word(CMD_RESPONSE, response_event(RK_KOD));
        send_word(CMD_RESPONSE, response_event(RK_ALARM));
        ev = response_event(RK_SERVER);
        ev.orig_us = ev.orig_us ^ 32'h8000_0000;
        send_word(CMD_RESPONSE, ev);
        ev = response_event(RK_SERVER);
        ev.orig_s = ev.orig_s ^ 32'h1;
        send_word(CMD_RESPONSE, ev);
        send_word(CMD_RESPONSE, response_event(RK_NOISE));
        send_word(CMD_RESPONSE, response_event(RK_SERVER));
        send_word(CMD_REQUEST, request_event($urandom, $urandom, 20'($urandom_range(0, 999999))));
        send_word(CMD_RESPONSE, response_event(RK_SERVER));

        for (int p = 1; p <= 6; p++) begin
            drain();
            case (p)
                1: apply_config(MIN_UPDATE - 32'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'd2);
                2: apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'h1234_FFFF, 32'd1);
                3: apply_config(MIN_UPDATE, RST_RETRY, RST_RETRY_MAX, 32'(RST_PORT), 32'd0);
                4: apply_config($urandom, $urandom, $urandom, $urandom, 32'd3);
                5: apply_config($urandom, $urandom_range(1, 100000), $urandom_range(1, 1000000),
                                $urandom, $urandom_range(0, 3));
                default: apply_config(32'd0, $urandom_range(1, 5000), $urandom,
                                      $urandom, 32'(RST_LEVEL));
            endcase
            if (p == 3)
                hold_output = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 40 == 0) begin
                    max_gap   = (p == 3 && i == 0) ? 0 : pick_idle();
                    max_stall = pick_idle();
                end
                send_random_item();
            end
        end
        drain();
        repeat (10) @(posedge aclk);

        $display("Ran %0d request and response events, %0d result words checked,", sent, checked);
        $display("under %0d register settings with random gaps and stalls on both channels.",
                 settings);
        if (fail_count == 0) begin
            $display("** sntp_response_check_and_offset_core: PASSED **");
        end else begin
            $display("** sntp_response_check_and_offset_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sntpco_pkg.sv
rtl/sntp_response_check_and_offset_core.sv
tb/sntp_offset_checker.sv
tb/sntp_response_check_and_offset_core_tb.sv
